// ===== rtl/core/spm_pkg.sv =====
// Shared types, widths and constants for the stereo pan mixer.
package spm_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int PAN_W       = 16;
  localparam int QUO_W       = 16;
  localparam int DIV_BITS    = 2;
  localparam int DIV_STAGES  = QUO_W / DIV_BITS;
  localparam int R_W         = 18;
  localparam int WGT_W       = 20;
  localparam int PROD_W      = SAMPLE_W + WGT_W;
  localparam int FRAC_SHIFT  = 17;
  localparam int SUM_W       = PROD_W + 1 - FRAC_SHIFT;
  localparam int ACC_W       = SUM_W + 1;

  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;

  localparam int IN_W        = 4 * SAMPLE_W + PAN_W;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W       = 2 * SAMPLE_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_MIX_MODE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PAN_SRC   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_PAN_CONST = CFG_IDX_W'(2);

  localparam logic [QUO_W-1:0]       DEN_BIAS = QUO_W'(4096);
  localparam logic signed [R_W-1:0]  R_ONE    = R_W'(65536);
  localparam logic signed [WGT_W-1:0] W_ONE   = WGT_W'(65536);
  localparam logic signed [WGT_W-1:0] W_FOUR  = WGT_W'(262144);
  localparam logic signed [WGT_W-1:0] W_FIVE  = WGT_W'(327680);

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

  typedef enum logic [1:0] {
    MODE_REPLACE = 2'd0,
    MODE_ACCUM   = 2'd1,
    MODE_MONO    = 2'd2
  } mix_mode_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [WGT_W-1:0]    weight_t;
  typedef logic signed [PROD_W-1:0]   prod_word_t;
  typedef logic signed [SUM_W-1:0]    sum_word_t;

  typedef struct packed {
    sample_t   left;
    sample_t   right;
    sample_t   prior_left;
    sample_t   prior_right;
    logic      last;
    mix_mode_t mode;
  } smp_t;

  typedef struct packed {
    logic [QUO_W-1:0] rem;
    logic [QUO_W-1:0] den;
    logic [QUO_W-1:0] quo;
    logic             neg;
    smp_t             smp;
  } div_t;

  typedef struct packed {
    prod_word_t pa;
    prod_word_t pb;
    prod_word_t pc;
    prod_word_t pd;
    sample_t    prior_left;
    sample_t    prior_right;
    logic       last;
    logic       acc;
  } prod_t;

endpackage

// ===== rtl/core/spm_div_stage.sv =====
// One pipeline stage of the pan quotient divider, two restoring steps per stage.
module spm_div_stage import spm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic in_valid,
  input  div_t in_data,
  output logic out_valid,
  output div_t out_data
);

  logic [QUO_W:0]   t1;
  logic [QUO_W:0]   t2;
  logic [QUO_W-1:0] r1;
  logic [QUO_W-1:0] r2;
  logic             b1;
  logic             b2;
  div_t             step;

  always_comb begin
    t1 = {in_data.rem, 1'b0};
    b1 = t1 >= {1'b0, in_data.den};
    r1 = b1 ? QUO_W'(t1 - {1'b0, in_data.den}) : t1[QUO_W-1:0];
    t2 = {r1, 1'b0};
    b2 = t2 >= {1'b0, in_data.den};
    r2 = b2 ? QUO_W'(t2 - {1'b0, in_data.den}) : t2[QUO_W-1:0];
    step     = in_data;
    step.rem = r2;
    step.quo = {in_data.quo[QUO_W-DIV_BITS-1:0], b1, b2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= step;
    end
  end

`ifndef ASSERT_OFF
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.rem < out_data.den)
    else $error("divider remainder not below divisor");
`endif

endmodule

// ===== rtl/core/spm_mix_mult.sv =====
// Pan bias and mix weights, then the four sample-by-weight products.
module spm_mix_mult import spm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  in_valid,
  input  div_t  in_data,
  output logic  out_valid,
  output prod_t out_data
);

  logic signed [R_W-1:0] qs;
  logic signed [R_W-1:0] r;
  weight_t               r1;
  weight_t               r2;
  weight_t               r3;
  weight_t               wa_next;
  weight_t               wb_next;
  weight_t               wc_next;
  weight_t               wd_next;

  logic    wv;
  weight_t wa;
  weight_t wb;
  weight_t wc;
  weight_t wd;
  smp_t    wsmp;

  always_comb begin
    qs = $signed({{(R_W-QUO_W){1'b0}}, in_data.quo});
    if (in_data.neg) begin
      qs = -qs;
    end
    r  = R_ONE + qs;
    r1 = WGT_W'(r);
    r2 = r1 <<< 1;
    r3 = r1 + r2;
    if (in_data.smp.mode == MODE_MONO) begin
      wa_next = W_FOUR - r2;
      wb_next = '0;
      wc_next = '0;
      wd_next = r2;
    end else begin
      wa_next = W_FIVE - r3;
      wb_next = r1 - W_ONE;
      wc_next = r3 - W_ONE;
      wd_next = W_ONE - r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wv        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      wv        <= in_valid;
      out_valid <= wv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wa   <= wa_next;
      wb   <= wb_next;
      wc   <= wc_next;
      wd   <= wd_next;
      wsmp <= in_data.smp;
      out_data.pa          <= wsmp.left * wa;
      out_data.pb          <= wsmp.right * wb;
      out_data.pc          <= wsmp.right * wc;
      out_data.pd          <= wsmp.left * wd;
      out_data.prior_left  <= wsmp.prior_left;
      out_data.prior_right <= wsmp.prior_right;
      out_data.last        <= wsmp.last;
      out_data.acc         <= (wsmp.mode == MODE_ACCUM) || (wsmp.mode == MODE_MONO);
    end
  end

endmodule

// ===== rtl/core/spm_accum_sat.sv =====
// Product sums with floor scaling, prior-sample accumulate, saturation and output word.
module spm_accum_sat import spm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    adv,
  input  logic    in_valid,
  input  prod_t   in_data,
  output logic    out_valid,
  output sample_t left_out,
  output sample_t right_out,
  output logic    clipped,
  output logic    last_out
);

  logic signed [PROD_W:0] lsum;
  logic signed [PROD_W:0] rsum;

  logic      sv;
  sum_word_t sl;
  sum_word_t sr;
  sample_t   spl;
  sample_t   spr;
  logic      slast;
  logic      sacc;

  logic signed [ACC_W-1:0] lacc;
  logic signed [ACC_W-1:0] racc;
  logic                    lhi;
  logic                    llo;
  logic                    rhi;
  logic                    rlo;

  always_comb begin
    lsum = (PROD_W+1)'(in_data.pa) + (PROD_W+1)'(in_data.pb);
    rsum = (PROD_W+1)'(in_data.pc) + (PROD_W+1)'(in_data.pd);
  end

  always_comb begin
    lacc = {sl[SUM_W-1], sl};
    racc = {sr[SUM_W-1], sr};
    if (sacc) begin
      lacc = lacc + {{(ACC_W-SAMPLE_W){spl[SAMPLE_W-1]}}, spl};
      racc = racc + {{(ACC_W-SAMPLE_W){spr[SAMPLE_W-1]}}, spr};
    end
    lhi = lacc > SAT_MAX;
    llo = lacc < SAT_MIN;
    rhi = racc > SAT_MAX;
    rlo = racc < SAT_MIN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      sv        <= in_valid;
      out_valid <= sv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sl    <= lsum[PROD_W:FRAC_SHIFT];
      sr    <= rsum[PROD_W:FRAC_SHIFT];
      spl   <= in_data.prior_left;
      spr   <= in_data.prior_right;
      slast <= in_data.last;
      sacc  <= in_data.acc;
      left_out  <= lhi ? SAT_MAX[SAMPLE_W-1:0] : (llo ? SAT_MIN[SAMPLE_W-1:0]
                                                      : lacc[SAMPLE_W-1:0]);
      right_out <= rhi ? SAT_MAX[SAMPLE_W-1:0] : (rlo ? SAT_MIN[SAMPLE_W-1:0]
                                                      : racc[SAMPLE_W-1:0]);
      clipped   <= lhi || llo || rhi || rlo;
      last_out  <= slast;
    end
  end

`ifndef ASSERT_OFF
  a_clip_at_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |->
      left_out == SAT_MAX[SAMPLE_W-1:0] || left_out == SAT_MIN[SAMPLE_W-1:0] ||
      right_out == SAT_MAX[SAMPLE_W-1:0] || right_out == SAT_MIN[SAMPLE_W-1:0])
    else $error("clip flag set without a saturated sample");
  a_replace_no_clip: assert property (@(posedge clk) disable iff (rst)
    adv && sv && !sacc && !lhi && !llo && !rhi && !rlo |=> !clipped)
    else $error("clip flag set for an in-range word");
`endif

endmodule

// ===== rtl/core/stereo_pan_mixer_unit.sv =====
// Stereo pan mixer top level: config registers, input stage and pipeline chain.
// Streaming stereo panner: each input word (left, right, pan, prior left, prior
// right) yields one output word (left, right) with a clip flag in m_tuser and the
// end-of-buffer mark passed through on tlast. The pipeline is 13 register stages
// deep: one input stage, eight divider stages forming the pan bias quotient two
// bits per stage, a weight stage, a multiply stage, a sum stage and the
// saturating output register. It takes one word per clock; the whole pipeline
// holds while the output word waits, and s_tready follows that hold. Write the
// configuration registers only while the pipeline is empty.
module stereo_pan_mixer_unit import spm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // left_in, right_in, pan_value, prior_left, prior_right
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tlast,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // left_out, right_out
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // clipped
  output logic                   m_tuser,
  output logic                   m_tlast
);

  localparam int PAN_LO = 2 * SAMPLE_W;

  mix_mode_t          mix_mode;
  logic               pan_from_item;
  logic [PAN_W-1:0]   pan_constant;

  logic               adv;
  logic [PAN_W-1:0]   pan_sel;
  logic [QUO_W-1:0]   mag;
  div_t               entry;

  logic               chain_valid [DIV_STAGES+1];
  div_t               chain_data  [DIV_STAGES+1];

  logic               mult_valid;
  prod_t              mult_data;
  sample_t            left_out;
  sample_t            right_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_mode      <= MODE_REPLACE;
      pan_from_item <= 1'b0;
      pan_constant  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIX_MODE:  mix_mode      <= mix_mode_t'(cfg_data[1:0]);
        REG_PAN_SRC:   pan_from_item <= cfg_data[0];
        REG_PAN_CONST: pan_constant  <= cfg_data[PAN_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  always_comb begin
    pan_sel = pan_from_item ? s_tdata[PAN_LO +: PAN_W] : pan_constant;
    mag     = pan_sel[PAN_W-1] ? QUO_W'(-pan_sel) : QUO_W'(pan_sel);
    entry.rem             = mag;
    entry.den             = DEN_BIAS + mag;
    entry.quo             = '0;
    entry.neg             = pan_sel[PAN_W-1];
    entry.smp.left        = s_tdata[0 +: SAMPLE_W];
    entry.smp.right       = s_tdata[SAMPLE_W +: SAMPLE_W];
    entry.smp.prior_left  = s_tdata[PAN_LO + PAN_W +: SAMPLE_W];
    entry.smp.prior_right = s_tdata[PAN_LO + PAN_W + SAMPLE_W +: SAMPLE_W];
    entry.smp.last        = s_tlast;
    entry.smp.mode        = mix_mode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_valid[0] <= 1'b0;
    end else if (adv) begin
      chain_valid[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      chain_data[0] <= entry;
    end
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    spm_div_stage u_div (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (chain_valid[g]),
      .in_data   (chain_data[g]),
      .out_valid (chain_valid[g+1]),
      .out_data  (chain_data[g+1])
    );
  end

  spm_mix_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (chain_valid[DIV_STAGES]),
    .in_data   (chain_data[DIV_STAGES]),
    .out_valid (mult_valid),
    .out_data  (mult_data)
  );

  spm_accum_sat u_sat (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (mult_valid),
    .in_data   (mult_data),
    .out_valid (m_tvalid),
    .left_out  (left_out),
    .right_out (right_out),
    .clipped   (m_tuser),
    .last_out  (m_tlast)
  );

  assign m_tdata = OUT_TDATA_W'({right_out, left_out});

`ifndef ASSERT_OFF
  a_hold_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while output word waits");
`endif

endmodule

// ===== verif/spm_checker.sv =====
// Checker for the stereo pan mixer: tracks config writes, predicts each output word, compares.
module spm_checker import spm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   s_tlast,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   m_tuser,
  input  logic                   m_tlast,
  output int                     mismatches,
  output int                     pending,
  output int                     checked,
  output int                     clip_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     PAN_LSB = 2 * SAMPLE_W;
  localparam int     PL_LSB  = PAN_LSB + PAN_W;
  localparam int     PR_LSB  = PL_LSB + SAMPLE_W;
  localparam longint S_HI    = (64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1;
  localparam longint S_LO    = -S_HI - 64'sd1;
  localparam longint Q16_ONE = 65536;

  typedef logic signed [PAN_W-1:0] pan_t;

  typedef struct {
    sample_t left;
    sample_t right;
    logic    clip;
    logic    last;
  } mix_word_t;

  mix_word_t   expected_mix[$];
  logic [1:0]  mode_q;
  logic        pan_src_q;
  pan_t        pan_const_q;

  function automatic longint sat_sample(longint x, inout logic clip);
    if (x > S_HI) begin
      clip = 1'b1;
      return S_HI;
    end
    if (x < S_LO) begin
      clip = 1'b1;
      return S_LO;
    end
    return x;
  endfunction

  function automatic mix_word_t pan_mix(logic [1:0] mode, pan_t pan, sample_t l, sample_t r,
                                        sample_t pl, sample_t pr, logic last);
    longint    p, mag, bias, lo, ro, wll, wrl, wrr, wlr;
    logic      clip;
    mix_word_t res;
    p    = pan;
    mag  = (p < 0) ? -p : p;
    bias = Q16_ONE + (p * Q16_ONE) / (64'sd4096 + mag);
    if (mode == MODE_MONO) begin
      lo = longint'(pl) + ((longint'(l) * (2 * Q16_ONE - bias)) >>> 16);
      ro = longint'(pr) + ((longint'(l) * bias) >>> 16);
    end else begin
      wll = 5 * Q16_ONE - 3 * bias;
      wrl = bias - Q16_ONE;
      wrr = 3 * bias - Q16_ONE;
      wlr = Q16_ONE - bias;
      lo  = (longint'(l) * wll + longint'(r) * wrl) >>> 17;
      ro  = (longint'(r) * wrr + longint'(l) * wlr) >>> 17;
      if (mode == MODE_ACCUM) begin
        lo = lo + longint'(pl);
        ro = ro + longint'(pr);
      end
    end
    clip      = 1'b0;
    lo        = sat_sample(lo, clip);
    ro        = sat_sample(ro, clip);
    res.left  = lo[SAMPLE_W-1:0];
    res.right = ro[SAMPLE_W-1:0];
    res.clip  = clip;
    res.last  = last;
    return res;
  endfunction

  function automatic void check_field(string field, longint want, longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    mix_word_t want;
    pan_t      pan;
    if (rst) begin
      mode_q      = MODE_REPLACE;
      pan_src_q   = 1'b0;
      pan_const_q = '0;
      expected_mix.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        pan = pan_src_q ? pan_t'(s_tdata[PAN_LSB +: PAN_W]) : pan_const_q;
        expected_mix.push_back(pan_mix(mode_q, pan, s_tdata[0 +: SAMPLE_W],
                                       s_tdata[SAMPLE_W +: SAMPLE_W], s_tdata[PL_LSB +: SAMPLE_W],
                                       s_tdata[PR_LSB +: SAMPLE_W], s_tlast));
      end
      if (m_tvalid && m_tready) begin
        if (expected_mix.size() == 0) begin
          mismatches++;
          $display("%0t: output word with nothing expected: expected none, got %h",
                   $time, m_tdata);
        end else begin
          want = expected_mix.pop_front();
          checked++;
          if (m_tuser) clip_count++;
          check_field("left_out", want.left, $signed(m_tdata[0 +: SAMPLE_W]));
          check_field("right_out", want.right, $signed(m_tdata[SAMPLE_W +: SAMPLE_W]));
          check_field("clipped", want.clip, m_tuser);
          check_field("last_out", want.last, m_tlast);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MIX_MODE:  mode_q      = cfg_data[1:0];
          REG_PAN_SRC:   pan_src_q   = cfg_data[0];
          REG_PAN_CONST: pan_const_q = cfg_data[PAN_W-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_mix.size();
  end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the stereo pan mixer: clock, reset, stimulus, back-pressure and verdict.
module tb;
  import spm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT    = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 550;
  localparam int PHASES       = 12;

  localparam logic [1:0]           MODE_SPARE    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONE_LOW  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_NONE_HIGH = {CFG_IDX_W{1'b1}};

  typedef logic signed [PAN_W-1:0] pan_t;

  localparam sample_t S_MAX   = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam sample_t S_MIN   = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam pan_t    PAN_MAX = {1'b0, {(PAN_W-1){1'b1}}};
  localparam pan_t    PAN_MIN = {1'b1, {(PAN_W-1){1'b0}}};
  localparam pan_t    PAN_ONE = pan_t'(4096);

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   s_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic                   s_tlast   = 1'b0;
  logic                   m_tready  = 1'b0;
  logic                   s_tready;
  logic                   m_tvalid;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;

  int idle_pct  = 0;
  int stall_pct = 0;
  int cycles    = 0;
  int words_sent = 0;
  int mismatches, pending, checked, clip_count;

  logic [1:0] mix_sched [4] = '{MODE_REPLACE, MODE_ACCUM, MODE_MONO, MODE_SPARE};

  stereo_pan_mixer_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  spm_checker i_chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked),
    .clip_count (clip_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words outstanding", cycles, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mix(logic [1:0] mode, logic src, pan_t pan);
    logic [CFG_DATA_W-1:0] v;
    v = CFG_DATA_W'($urandom);
    v[1:0] = mode;
    write_reg(REG_MIX_MODE, v);
    v = CFG_DATA_W'($urandom);
    v[0] = src;
    write_reg(REG_PAN_SRC, v);
    write_reg(REG_PAN_CONST, pan);
  endtask

  task automatic send_sample(sample_t l, sample_t r, pan_t pan, sample_t pl, sample_t pr,
                             logic last);
    logic rdy;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tlast  <= last;
    s_tdata  <= IN_TDATA_W'({pr, pl, pan, r, l});
    do begin
      @(negedge clk);
      rdy = s_tready;
      @(posedge clk);
    end while (!rdy);
    words_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(9))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return sample_t'($urandom_range(511)) - sample_t'(256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic pan_t rand_pan();
    case ($urandom_range(7))
      0:       return PAN_MAX;
      1:       return PAN_MIN;
      2:       return pan_t'($urandom_range(15)) - pan_t'(8);
      3:       return ($urandom_range(1) ? PAN_ONE : -PAN_ONE) + pan_t'($urandom_range(3))
                      - pan_t'(1);
      default: return pan_t'($urandom);
    endcase
  endfunction

  initial begin
    logic [1:0] mode;
    pan_t       pan;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_mix(MODE_REPLACE, 1'b1, '0);
    send_sample(S_MAX, S_MAX, PAN_MAX, '0, '0, 1'b0);
    send_sample(S_MIN, S_MIN, PAN_MIN, S_MAX, S_MIN, 1'b1);
    send_sample(S_MAX, S_MIN, '0, S_MIN, S_MAX, 1'b0);
    send_sample(S_MIN, S_MAX, -pan_t'(1), '0, '0, 1'b0);
    send_sample('0, '0, pan_t'(1), S_MAX, S_MAX, 1'b1);
    drain();

    set_mix(MODE_ACCUM, 1'b1, PAN_MIN);
    send_sample(S_MAX, S_MAX, PAN_MAX, S_MAX, S_MAX, 1'b0);
    send_sample(S_MIN, S_MIN, PAN_MIN, S_MIN, S_MIN, 1'b0);
    send_sample(S_MAX, S_MIN, '0, S_MIN, S_MAX, 1'b1);
    send_sample('0, '0, PAN_ONE, -sample_t'(1), sample_t'(1), 1'b0);
    drain();

    set_mix(MODE_MONO, 1'b1, PAN_MAX);
    send_sample(S_MAX, S_MIN, PAN_MAX, S_MAX, S_MIN, 1'b0);
    send_sample(S_MIN, S_MAX, PAN_MIN, S_MIN, S_MAX, 1'b1);
    send_sample(S_MAX, '0, '0, '0, '0, 1'b0);
    send_sample(S_MIN, S_MAX, -PAN_ONE, S_MAX, S_MAX, 1'b0);
    drain();

    set_mix(MODE_SPARE, 1'b0, PAN_MAX);
    send_sample(S_MAX, S_MIN, PAN_MIN, S_MAX, S_MAX, 1'b0);
    send_sample(S_MIN, S_MAX, '0, S_MIN, S_MIN, 1'b1);
    drain();

    write_reg(REG_PAN_CONST, PAN_MIN);
    send_sample(S_MAX, S_MAX, PAN_MAX, '0, '0, 1'b0);
    send_sample(S_MIN, '0, PAN_MAX, '0, '0, 1'b1);
    drain();

    write_reg(REG_NONE_LOW, CFG_DATA_W'($urandom));
    write_reg(REG_NONE_HIGH, {CFG_DATA_W{1'b1}});
    send_sample(S_MAX, S_MIN, PAN_MAX, S_MAX, S_MIN, 1'b1);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      mode = mix_sched[(ph + ph / 4) % 4];
      case (ph)
        1:       pan = PAN_MAX;
        2:       pan = PAN_MIN;
        5:       pan = '0;
        default: pan = rand_pan();
      endcase
      set_mix(mode, ((ph / 2) % 2) != 0, pan);
      if (ph == 9) write_reg(REG_NONE_LOW, CFG_DATA_W'($urandom));
      for (int k = 0; k < RANDOM_ITEMS / PHASES; k++) begin
        if (ph == 6 && k == 20) drain();
        send_sample(rand_sample(), rand_sample(), rand_pan(), rand_sample(), rand_sample(),
                    $urandom_range(7) == 0);
      end
      drain();
    end

    $display("Summary: %0d words sent over all mix modes, both pan sources and pan extremes,",
             words_sent);
    $display("  with idle and stall phases; %0d words checked, %0d clipped, %0d mismatches",
             checked, clip_count, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== stereo_pan_mixer_unit.f =====
rtl/core/spm_pkg.sv
rtl/core/spm_div_stage.sv
rtl/core/spm_mix_mult.sv
rtl/core/spm_accum_sat.sv
rtl/core/stereo_pan_mixer_unit.sv
verif/spm_checker.sv
verif/tb.sv
